// ----- design/cursor_list_sequence_assert.svh -----
// Assertion macros shared by the cursor list sequence modules
`ifndef CURSOR_LIST_SEQUENCE_ASSERT_SVH
`define CURSOR_LIST_SEQUENCE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define CLS_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CLS_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent a fixed number of cycles later
`define CLS_ASSERT_AFTER(label, ante, cycles, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |-> ##cycles (cons)) else $error(msg);

`endif

// ----- design/csl_pkg.sv -----
// Package: constants, codes, types and helpers for the cursor list sequence
`timescale 1ns / 1ps

package csl_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int PTR_W    = $clog2(CAPACITY + 1);
   localparam int WORD_W   = 32;
   localparam int COUNT_W  = 7;

   localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

   localparam logic [2:0] REQ_RESTART = 3'd0;
   localparam logic [2:0] REQ_ADVANCE = 3'd1;
   localparam logic [2:0] REQ_INSERT  = 3'd2;
   localparam logic [2:0] REQ_ATTACH  = 3'd3;
   localparam logic [2:0] REQ_REMOVE  = 3'd4;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NO_CURRENT = 2'd1;
   localparam logic [1:0] ST_POOL_FULL  = 2'd2;

   typedef logic [PTR_W-1:0] ptr_type;

   typedef struct packed {
      logic    take;
      logic    give;
      ptr_type node;
      ptr_type free_link;
   } alloc_cmd_type;

   typedef struct packed {
      logic    full;
      ptr_type node;
   } alloc_grant_type;

   function automatic logic ptr_live(input ptr_type p);
      return p < NIL;
   endfunction

endpackage

// ----- design/cursor_list_sequence.sv -----
// Top level: request sequencer, list pointers and node memories
`timescale 1ns / 1ps
`include "cursor_list_sequence_assert.svh"

// An item is taken when start is high and busy low. Its result appears on the
// rsp_ ports for one cycle, marked by rsp_strobe, after the states RDA, RDB,
// UPD, WR2 and RDW, and must be taken then. busy is low in the strobe cycle,
// so a new item can be taken there, but not before the last one is through.
// The state sequence comes from the next-link memory with one read and one
// write port, which serves two link reads (free chain head, then cursor) and
// up to two link writes per item, followed by one read of the word memory at
// the new cursor. No clearing pass after reset.

module cursor_list_sequence import csl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_type,
   input  logic [WORD_W-1:0] req_entry_value,
   output logic              rsp_strobe,
   output logic [WORD_W-1:0] rsp_current_value,
   output logic              rsp_has_current,
   output logic [COUNT_W-1:0] rsp_item_count,
   output logic [1:0]        rsp_status
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RDA  = 3'd1;
   localparam logic [2:0] S_RDB  = 3'd2;
   localparam logic [2:0] S_UPD  = 3'd3;
   localparam logic [2:0] S_WR2  = 3'd4;
   localparam logic [2:0] S_RDW  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [2:0]        op_ff;
   logic [WORD_W-1:0] word_ff;
   ptr_type           first_ff, first_in;
   ptr_type           last_ff, last_in;
   ptr_type           cur_ff, cur_in;
   ptr_type           before_ff, before_in;
   logic [1:0]        status_ff, status_in;
   ptr_type           free_link_ff;
   logic              w2_en_ff, w2_en_in;
   ptr_type           w2_addr_ff, w2_addr_in;
   ptr_type           w2_data_ff, w2_data_in;

   logic              w1_en;
   ptr_type           w1_addr, w1_data;
   logic              word_we;
   logic              take, give;
   logic              accept, upd;

   ptr_type           next_rd;
   ptr_type           cur_link;
   logic              nx_wr_en;
   ptr_type           nx_wr_addr, nx_wr_data;
   logic [WORD_W-1:0] word_rd;

   ptr_type           free_head, count;
   alloc_cmd_type     acmd;
   alloc_grant_type   grant;
   ptr_type           n;

   assign busy   = !(state_ff == S_IDLE || state_ff == S_OUT);
   assign accept = start && !busy;
   assign upd    = (state_ff == S_UPD);
   assign n      = grant.node;

   assign cur_link = (ptr_live(cur_ff) && ptr_live(next_rd)) ? next_rd : NIL;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE, S_OUT: state_in = accept ? S_RDA : S_IDLE;
         S_RDA:         state_in = S_RDB;
         S_RDB:         state_in = S_UPD;
         S_UPD:         state_in = S_WR2;
         S_WR2:         state_in = S_RDW;
         S_RDW:         state_in = S_OUT;
         default:       state_in = S_IDLE;
      endcase
   end

   always_comb begin
      first_in   = first_ff;
      last_in    = last_ff;
      cur_in     = cur_ff;
      before_in  = before_ff;
      status_in  = ST_OK;
      w1_en      = 1'b0;
      w1_addr    = n;
      w1_data    = NIL;
      w2_en_in   = 1'b0;
      w2_addr_in = before_ff;
      w2_data_in = n;
      word_we    = 1'b0;
      take       = 1'b0;
      give       = 1'b0;
      case (op_ff)
         REQ_RESTART: begin
            before_in = NIL;
            cur_in    = first_ff;
         end
         REQ_ADVANCE: begin
            if (ptr_live(cur_ff)) begin
               before_in = cur_ff;
               cur_in    = cur_link;
            end else begin
               status_in = ST_NO_CURRENT;
            end
         end
         REQ_INSERT: begin
            if (grant.full) begin
               status_in = ST_POOL_FULL;
            end else begin
               take    = 1'b1;
               word_we = 1'b1;
               w1_en   = 1'b1;
               cur_in  = n;
               if (ptr_live(cur_ff) && ptr_live(before_ff)) begin
                  w1_data    = cur_ff;
                  w2_en_in   = 1'b1;
                  w2_addr_in = before_ff;
               end else begin
                  w1_data = first_ff;
                  if (!ptr_live(first_ff)) begin
                     last_in = n;
                  end
                  first_in  = n;
                  before_in = NIL;
               end
            end
         end
         REQ_ATTACH: begin
            if (grant.full) begin
               status_in = ST_POOL_FULL;
            end else begin
               take    = 1'b1;
               word_we = 1'b1;
               w1_en   = 1'b1;
               cur_in  = n;
               if (ptr_live(cur_ff)) begin
                  w1_data    = cur_link;
                  w2_en_in   = 1'b1;
                  w2_addr_in = cur_ff;
                  if (last_ff == cur_ff) begin
                     last_in = n;
                  end
                  before_in = cur_ff;
               end else if (!ptr_live(first_ff)) begin
                  first_in  = n;
                  last_in   = n;
                  before_in = NIL;
               end else begin
                  if (ptr_live(last_ff)) begin
                     w2_en_in   = 1'b1;
                     w2_addr_in = last_ff;
                  end
                  before_in = last_ff;
                  last_in   = n;
               end
            end
         end
         REQ_REMOVE: begin
            if (ptr_live(cur_ff)) begin
               give    = 1'b1;
               w1_en   = 1'b1;
               w1_addr = cur_ff;
               w1_data = free_head;
               if (first_ff == last_ff) begin
                  first_in  = NIL;
                  last_in   = NIL;
                  cur_in    = NIL;
                  before_in = NIL;
               end else if (cur_ff == first_ff || !ptr_live(before_ff)) begin
                  first_in  = cur_link;
                  cur_in    = cur_link;
                  before_in = NIL;
               end else if (cur_ff == last_ff) begin
                  w2_en_in   = 1'b1;
                  w2_addr_in = before_ff;
                  w2_data_in = NIL;
                  last_in    = before_ff;
                  cur_in     = NIL;
               end else begin
                  w2_en_in   = 1'b1;
                  w2_addr_in = before_ff;
                  w2_data_in = cur_link;
                  cur_in     = cur_link;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         first_ff  <= NIL;
         last_ff   <= NIL;
         cur_ff    <= NIL;
         before_ff <= NIL;
         w2_en_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (upd) begin
            first_ff  <= first_in;
            last_ff   <= last_in;
            cur_ff    <= cur_in;
            before_ff <= before_in;
            w2_en_ff  <= w2_en_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_type;
         word_ff <= req_entry_value;
      end
      if (state_ff == S_RDB) begin
         free_link_ff <= next_rd;
      end
      if (upd) begin
         status_ff  <= status_in;
         w2_addr_ff <= w2_addr_in;
         w2_data_ff <= w2_data_in;
      end
   end

   assign acmd.take      = upd && take;
   assign acmd.give      = upd && give;
   assign acmd.node      = cur_ff;
   assign acmd.free_link = free_link_ff;

   csl_alloc u_alloc (
      .clock     (clock),
      .reset     (reset),
      .cmd       (acmd),
      .free_head (free_head),
      .grant     (grant),
      .count     (count)
   );

   assign nx_wr_en   = (upd && w1_en) || (state_ff == S_WR2 && w2_en_ff);
   assign nx_wr_addr = upd ? w1_addr : w2_addr_ff;
   assign nx_wr_data = upd ? w1_data : w2_data_ff;

   csl_ram #(
      .WIDTH (PTR_W),
      .DEPTH (CAPACITY),
      .ADDR_W(IDX_W)
   ) u_next_ram (
      .clock  (clock),
      .wr_en  (nx_wr_en),
      .wr_addr(nx_wr_addr[IDX_W-1:0]),
      .wr_data(nx_wr_data),
      .rd_en  (state_ff == S_RDA || state_ff == S_RDB),
      .rd_addr(state_ff == S_RDA ? free_head[IDX_W-1:0] : cur_ff[IDX_W-1:0]),
      .rd_data(next_rd)
   );

   csl_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CAPACITY),
      .ADDR_W(IDX_W)
   ) u_word_ram (
      .clock  (clock),
      .wr_en  (upd && word_we),
      .wr_addr(n[IDX_W-1:0]),
      .wr_data(word_ff),
      .rd_en  (state_ff == S_RDW),
      .rd_addr(cur_ff[IDX_W-1:0]),
      .rd_data(word_rd)
   );

   assign rsp_strobe        = (state_ff == S_OUT);
   assign rsp_has_current   = ptr_live(cur_ff);
   assign rsp_current_value = ptr_live(cur_ff) ? word_rd : '0;
   assign rsp_item_count    = COUNT_W'(count);
   assign rsp_status        = status_ff;

   `CLS_ASSERT_IMPLIES(a_busy_fall, $fell(busy), rsp_strobe, "busy dropped without a result")
   `CLS_ASSERT_AFTER(a_latency, accept, 6, rsp_strobe, "result not delivered after six cycles")
   `CLS_ASSERT_IMPLIES(a_empty_cursor, !ptr_live(first_ff), !ptr_live(cur_ff) && !ptr_live(last_ff),
      "cursor or tail live on empty list")

endmodule

// ----- design/csl_ram.sv -----
// Generic single write port, single read port RAM with registered read data
`timescale 1ns / 1ps

module csl_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/csl_alloc.sv -----
// Node allocator: free chain head, never-used mark and item count
`timescale 1ns / 1ps
`include "cursor_list_sequence_assert.svh"

module csl_alloc import csl_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  alloc_cmd_type   cmd,
   output ptr_type         free_head,
   output alloc_grant_type grant,
   output ptr_type         count
);

   ptr_type free_head_ff, free_head_in;
   ptr_type never_used_ff, never_used_in;
   ptr_type count_ff, count_in;

   always_comb begin
      grant.full = !ptr_live(free_head_ff) && (never_used_ff >= NIL);
      grant.node = ptr_live(free_head_ff) ? free_head_ff : never_used_ff;
   end

   always_comb begin
      free_head_in  = free_head_ff;
      never_used_in = never_used_ff;
      count_in      = count_ff;
      if (cmd.take) begin
         if (ptr_live(free_head_ff)) begin
            free_head_in = ptr_live(cmd.free_link) ? cmd.free_link : NIL;
         end else begin
            never_used_in = never_used_ff + PTR_W'(1);
         end
         count_in = count_ff + PTR_W'(1);
      end else if (cmd.give) begin
         free_head_in = cmd.node;
         if (count_ff != '0) begin
            count_in = count_ff - PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= NIL;
         never_used_ff <= '0;
         count_ff      <= '0;
      end else begin
         free_head_ff  <= free_head_in;
         never_used_ff <= never_used_in;
         count_ff      <= count_in;
      end
   end

   assign free_head = free_head_ff;
   assign count     = count_ff;

   `CLS_ASSERT_HOLDS(a_count_range, count_ff <= NIL, "item count above capacity")
   `CLS_ASSERT_HOLDS(a_mark_range, never_used_ff <= NIL, "never-used mark above capacity")
   `CLS_ASSERT_IMPLIES(a_take_not_full, cmd.take, !grant.full && !cmd.give, "take from full pool")

endmodule

// ----- bench/tb_top.sv -----
// Testbench for cursor_list_sequence: directed and random list requests checked against a behavioural list model
`timescale 1ns / 1ps

module tb_top import csl_pkg::*; ();

   localparam logic [2:0] REQ_SPARE_LO  = 3'd5;
   localparam logic [2:0] REQ_SPARE_MID = 3'd6;
   localparam logic [2:0] REQ_SPARE_HI  = 3'd7;
   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 12;

   typedef struct packed {
      logic [2:0]        op;
      logic [WORD_W-1:0] word;
   } list_request_type;

   typedef struct packed {
      logic [WORD_W-1:0]  value;
      logic               present;
      logic [COUNT_W-1:0] count;
      logic [1:0]         status;
   } cursor_view_type;

   typedef enum int {MIX_GROW, MIX_WALK, MIX_SHRINK, MIX_EVEN} request_mix_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_type;
   logic [WORD_W-1:0]  req_entry_value;
   logic               rsp_strobe;
   logic [WORD_W-1:0]  rsp_current_value;
   logic               rsp_has_current;
   logic [COUNT_W-1:0] rsp_item_count;
   logic [1:0]         rsp_status;

   list_request_type pending_requests[$];
   cursor_view_type  cursor_views_due[$];
   int               request_total;
   int               requests_sent;
   int               error_count;
   int               quiet_cycles;

   // list model state
   logic [WORD_W-1:0] model_word [CAPACITY];
   ptr_type           model_link [CAPACITY];
   ptr_type           model_head, model_tail, model_cur, model_prev, model_free;
   int                model_count, model_fresh;

   cursor_list_sequence dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_entry_value   (req_entry_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_current_value (rsp_current_value),
      .rsp_has_current   (rsp_has_current),
      .rsp_item_count    (rsp_item_count),
      .rsp_status        (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic in_pool(input ptr_type p);
      return p < CAPACITY;
   endfunction

   function automatic ptr_type link_after(input ptr_type n);
      if (!in_pool(n)) return NIL;
      return in_pool(model_link[n]) ? model_link[n] : NIL;
   endfunction

   task automatic clear_list_model();
      for (int i = 0; i < CAPACITY; i++) begin
         model_word[i] = '0;
         model_link[i] = '0;
      end
      model_head  = NIL;
      model_tail  = NIL;
      model_cur   = NIL;
      model_prev  = NIL;
      model_free  = NIL;
      model_count = 0;
      model_fresh = 0;
   endtask

   // freed nodes first, then untouched ones in index order
   task automatic claim_node(input logic [WORD_W-1:0] w, input ptr_type nx,
                             output ptr_type n);
      if (in_pool(model_free)) begin
         n = model_free;
         model_free = link_after(n);
      end else if (model_fresh < CAPACITY) begin
         n = ptr_type'(model_fresh);
         model_fresh++;
      end else begin
         n = NIL;
      end
      if (in_pool(n)) begin
         model_word[n] = w;
         model_link[n] = nx;
         model_count++;
      end
   endtask

   task automatic release_node(input ptr_type n);
      if (in_pool(n)) begin
         model_link[n] = model_free;
         model_free = n;
         if (model_count > 0) model_count--;
      end
   endtask

   task automatic apply_list_request(input list_request_type rq,
                                     output cursor_view_type view);
      ptr_type    n;
      logic [1:0] st;
      st = ST_OK;
      case (rq.op)
         REQ_RESTART: begin
            model_prev = NIL;
            model_cur  = model_head;
         end
         REQ_ADVANCE: begin
            if (in_pool(model_cur)) begin
               model_prev = model_cur;
               model_cur  = link_after(model_cur);
            end else begin
               st = ST_NO_CURRENT;
            end
         end
         REQ_INSERT: begin
            if (in_pool(model_cur) && in_pool(model_prev)) begin
               claim_node(rq.word, model_cur, n);
               if (!in_pool(n)) begin
                  st = ST_POOL_FULL;
               end else begin
                  model_link[model_prev] = n;
                  model_cur = n;
               end
            end else begin
               claim_node(rq.word, model_head, n);
               if (!in_pool(n)) begin
                  st = ST_POOL_FULL;
               end else begin
                  if (!in_pool(model_head)) model_tail = n;
                  model_head = n;
                  model_cur  = n;
                  model_prev = NIL;
               end
            end
         end
         REQ_ATTACH: begin
            if (in_pool(model_cur)) begin
               claim_node(rq.word, link_after(model_cur), n);
               if (!in_pool(n)) begin
                  st = ST_POOL_FULL;
               end else begin
                  model_link[model_cur] = n;
                  if (model_tail == model_cur) model_tail = n;
                  model_prev = model_cur;
                  model_cur  = n;
               end
            end else if (!in_pool(model_head)) begin
               claim_node(rq.word, NIL, n);
               if (!in_pool(n)) begin
                  st = ST_POOL_FULL;
               end else begin
                  model_head = n;
                  model_tail = n;
                  model_cur  = n;
                  model_prev = NIL;
               end
            end else begin
               claim_node(rq.word, NIL, n);
               if (!in_pool(n)) begin
                  st = ST_POOL_FULL;
               end else begin
                  if (in_pool(model_tail)) model_link[model_tail] = n;
                  model_prev = model_tail;
                  model_tail = n;
                  model_cur  = n;
               end
            end
         end
         REQ_REMOVE: begin
            if (in_pool(model_cur)) begin
               n = model_cur;
               if (model_head == model_tail) begin
                  model_head = NIL;
                  model_tail = NIL;
                  model_cur  = NIL;
                  model_prev = NIL;
               end else if (n == model_head || !in_pool(model_prev)) begin
                  model_head = link_after(n);
                  model_cur  = model_head;
                  model_prev = NIL;
               end else if (n == model_tail) begin
                  model_link[model_prev] = NIL;
                  model_tail = model_prev;
                  model_cur  = NIL;
               end else begin
                  model_link[model_prev] = link_after(n);
                  model_cur = link_after(n);
               end
               release_node(n);
            end
         end
         default: begin
         end
      endcase
      view.present = in_pool(model_cur);
      view.value   = in_pool(model_cur) ? model_word[model_cur] : '0;
      view.count   = COUNT_W'(model_count);
      view.status  = st;
   endtask

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [2:0] pick_op(input request_mix_type mix);
      int r;
      r = $urandom_range(99);
      if (r >= 95) return 3'($urandom_range(7));
      case (mix)
         MIX_GROW: begin
            if (r < 40) return REQ_INSERT;
            if (r < 80) return REQ_ATTACH;
            if (r < 87) return REQ_ADVANCE;
            if (r < 91) return REQ_RESTART;
            return REQ_REMOVE;
         end
         MIX_WALK: begin
            if (r < 15) return REQ_INSERT;
            if (r < 30) return REQ_ATTACH;
            if (r < 62) return REQ_ADVANCE;
            if (r < 77) return REQ_RESTART;
            return REQ_REMOVE;
         end
         MIX_SHRINK: begin
            if (r < 8)  return REQ_INSERT;
            if (r < 16) return REQ_ATTACH;
            if (r < 36) return REQ_ADVANCE;
            if (r < 50) return REQ_RESTART;
            return REQ_REMOVE;
         end
         default: return 3'($urandom_range(4));
      endcase
   endfunction

   function automatic int sender_idle_pct();
      if (requests_sent < request_total / 3)     return 8;
      if (requests_sent < 2 * request_total / 3) return 56;
      return 0;
   endfunction

   task automatic queue_request(input logic [2:0] op, input logic [WORD_W-1:0] w);
      list_request_type rq;
      rq.op   = op;
      rq.word = w;
      pending_requests.push_back(rq);
   endtask

   task automatic queue_random(input request_mix_type mix, input int n);
      for (int i = 0; i < n; i++) queue_request(pick_op(mix), random_word());
   endtask

   // driver
   always @(posedge clock) begin : drive_requests
      list_request_type rq;
      cursor_view_type  view;
      logic             taken;
      if (reset) begin
         start           <= 1'b0;
         req_type        <= REQ_RESTART;
         req_entry_value <= '0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            rq.op   = req_type;
            rq.word = req_entry_value;
            apply_list_request(rq, view);
            cursor_views_due.push_back(view);
         end
         if (!start || taken) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
               rq = pending_requests.pop_front();
               requests_sent++;
               start           <= 1'b1;
               req_type        <= rq.op;
               req_entry_value <= rq.word;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : check_responses
      cursor_view_type want;
      if (!reset && rsp_strobe) begin
         if (cursor_views_due.size() == 0) begin
            flag_error("response with no request outstanding");
         end else begin
            want = cursor_views_due.pop_front();
            if (rsp_current_value !== want.value)
               flag_error($sformatf("current_value %h, expected %h",
                                    rsp_current_value, want.value));
            if (rsp_has_current !== want.present)
               flag_error($sformatf("has_current %b, expected %b",
                                    rsp_has_current, want.present));
            if (rsp_item_count !== want.count)
               flag_error($sformatf("item_count %0d, expected %0d",
                                    rsp_item_count, want.count));
            if (rsp_status !== want.status)
               flag_error($sformatf("status %0d, expected %0d", rsp_status, want.status));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_type        = REQ_RESTART;
      req_entry_value = '0;
      error_count     = 0;
      requests_sent   = 0;
      quiet_cycles    = 0;
      clear_list_model();

      // directed: empty list, head/tail/middle edits, running off the end, spare codes
      queue_request(REQ_RESTART, '0);
      queue_request(REQ_ADVANCE, '0);
      queue_request(REQ_REMOVE, '0);
      queue_request(REQ_INSERT, 32'h0000_0000);
      queue_request(REQ_ATTACH, 32'hFFFF_FFFF);
      queue_request(REQ_INSERT, 32'h5A5A_5A5A);
      queue_request(REQ_ADVANCE, '1);
      queue_request(REQ_ADVANCE, '0);
      queue_request(REQ_ADVANCE, '0);
      queue_request(REQ_ATTACH, 32'hA5A5_A5A5);
      queue_request(REQ_RESTART, '0);
      queue_request(REQ_INSERT, 32'h1234_5678);
      queue_request(REQ_REMOVE, '0);
      queue_request(REQ_ADVANCE, '0);
      queue_request(REQ_REMOVE, '0);
      queue_request(REQ_ADVANCE, '0);
      queue_request(REQ_REMOVE, '0);
      queue_request(REQ_INSERT, 32'h8000_0001);
      queue_request(REQ_SPARE_LO, '1);
      queue_request(REQ_SPARE_MID, '1);
      queue_request(REQ_SPARE_HI, '1);
      queue_request(REQ_RESTART, '0);
      queue_request(REQ_REMOVE, '0);
      queue_request(REQ_REMOVE, '0);
      queue_request(REQ_REMOVE, '0);

      // random: fill to a full pool, walk, drain, refill, then an even mix
      queue_random(MIX_GROW, 110);
      queue_random(MIX_WALK, 50);
      queue_random(MIX_SHRINK, 110);
      queue_random(MIX_GROW, 70);
      queue_random(MIX_EVEN, 60);
      request_total = pending_requests.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_requests.size() != 0 || start || cursor_views_due.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (cursor_views_due.size() != 0)
         flag_error($sformatf("%0d responses never arrived", cursor_views_due.size()));

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+design
design/csl_pkg.sv
design/csl_ram.sv
design/csl_alloc.sv
design/cursor_list_sequence.sv
bench/tb_top.sv
